[hw/rtl/ssrm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssrm_pkg
// Shared types and constants for the stream stall recovery monitor.
// ----------------------------------------------------------------------------
package ssrm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECOVERY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCALATION_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_TIMEOUT_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TICKS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_START_TICKS   = 3'd4;

    localparam logic [7:0]  RST_MAX_RECOVERY       = 8'd3;
    localparam logic        RST_ESCALATION_ENABLE  = 1'b1;
    localparam logic [15:0] RST_HANDLER_TIMEOUT_MS = 16'd2000;
    localparam logic [3:0]  RST_STALL_TICKS        = 4'd3;
    localparam logic [3:0]  RST_COLD_START_TICKS   = 4'd5;

    localparam logic [7:0]  RECOVERY_MAX = 8'd255;

    typedef enum logic [1:0] {
        CMD_TICK          = 2'd0,
        CMD_HANDLER_ENTER = 2'd1,
        CMD_HANDLER_EXIT  = 2'd2,
        CMD_SESSION_RESET = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_HANDLER_WEDGED = 2'd1,
        ST_STREAM_WEDGED  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_HANDLER_RESET = 3'd1,
        ACT_ESCALATED     = 3'd2,
        ACT_RECOVER_RST   = 3'd3,
        ACT_RECOVER_NORST = 3'd4,
        ACT_CAPPED_WAIT   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_STALL = 2'd1,
        FAULT_COLD  = 2'd2
    } fault_t;

    typedef struct packed {
        logic [7:0]  max_recovery;
        logic        escalation_enable;
        logic [15:0] handler_timeout_ms;
        logic [3:0]  stall_ticks;
        logic [3:0]  cold_start_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic [31:0] dma_count;
        logic        sm_busy_wait;
        logic        sm_streaming_active;
        logic        app_active;
        logic        clock_healthy;
    } item_t;

    typedef struct packed {
        status_t    status;
        action_t    action;
        fault_t     fault_kind;
        logic       fault_count_bump;
        logic       clear_dma_count;
        logic [7:0] recovery_count;
    } result_t;

endpackage
`default_nettype wire

[hw/rtl/stream_stall_recovery_monitor_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stream_stall_recovery_monitor_top
// Streaming health monitor with handler timeout, stall and cold-start
// detection and recovery selection.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item, and a new item is taken
// every cycle while the input is not stalled: the item goes through an input
// register, combinational decision logic that also updates the monitor state,
// and a result register. Stall on the input rises only while a finished
// result is held by a stalled output. Configuration writes are always ready
// and take effect on the next item.
module stream_stall_recovery_monitor_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ssrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ssrm_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      command,
    input  wire logic [31:0]                     now_ms,
    input  wire logic [31:0]                     dma_count,
    input  wire logic                            sm_busy_wait,
    input  wire logic                            sm_streaming_active,
    input  wire logic                            app_active,
    input  wire logic                            clock_healthy,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           status,
    output logic [2:0]                           action,
    output logic [1:0]                           fault_kind,
    output logic                                 fault_count_bump,
    output logic                                 clear_dma_count,
    output logic [7:0]                           recovery_count
);

    ssrm_pkg::cfg_t    cfg_reg;
    logic              in_valid_reg;
    ssrm_pkg::item_t   item_reg;
    logic              out_valid_reg;
    ssrm_pkg::result_t result_reg;
    ssrm_pkg::result_t result_next;
    logic              advance;
    logic              fire;
    logic              in_take;

    assign cfg_ready = 1'b1;
    assign advance   = !(out_valid_reg && out_stall);
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_recovery       <= ssrm_pkg::RST_MAX_RECOVERY;
            cfg_reg.escalation_enable  <= ssrm_pkg::RST_ESCALATION_ENABLE;
            cfg_reg.handler_timeout_ms <= ssrm_pkg::RST_HANDLER_TIMEOUT_MS;
            cfg_reg.stall_ticks        <= ssrm_pkg::RST_STALL_TICKS;
            cfg_reg.cold_start_ticks   <= ssrm_pkg::RST_COLD_START_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssrm_pkg::CFG_MAX_RECOVERY:       cfg_reg.max_recovery       <= cfg_data[7:0];
                ssrm_pkg::CFG_ESCALATION_ENABLE:  cfg_reg.escalation_enable  <= cfg_data[0];
                ssrm_pkg::CFG_HANDLER_TIMEOUT_MS: cfg_reg.handler_timeout_ms <= cfg_data;
                ssrm_pkg::CFG_STALL_TICKS:        cfg_reg.stall_ticks        <= cfg_data[3:0];
                ssrm_pkg::CFG_COLD_START_TICKS:   cfg_reg.cold_start_ticks   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance || !in_valid_reg)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.command             <= command;
            item_reg.now_ms              <= now_ms;
            item_reg.dma_count           <= dma_count;
            item_reg.sm_busy_wait        <= sm_busy_wait;
            item_reg.sm_streaming_active <= sm_streaming_active;
            item_reg.app_active          <= app_active;
            item_reg.clock_healthy       <= clock_healthy;
        end
    end

    ssrm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .fire   (fire),
        .result (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = result_reg.status;
    assign action           = result_reg.action;
    assign fault_kind       = result_reg.fault_kind;
    assign fault_count_bump = result_reg.fault_count_bump;
    assign clear_dma_count  = result_reg.clear_dma_count;
    assign recovery_count   = result_reg.recovery_count;

endmodule
`default_nettype wire

[hw/rtl/ssrm_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssrm_core
// Monitor state and the combinational decision logic for one item.
// ----------------------------------------------------------------------------
module ssrm_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssrm_pkg::cfg_t   cfg,
    input  wire ssrm_pkg::item_t  item,
    input  wire logic             fire,
    output ssrm_pkg::result_t     result
);

    logic [31:0]      enter_time_reg, enter_time_next;
    logic             handler_busy_reg, handler_busy_next;
    logic [31:0]      prev_dma_reg, prev_dma_next;
    logic [3:0]       stall_cnt_reg, stall_cnt_next;
    logic [3:0]       cold_cnt_reg, cold_cnt_next;
    ssrm_pkg::fault_t fault_reg, fault_next;
    logic [7:0]       recov_reg, recov_next;
    logic             escalated_reg, escalated_next;

    logic [31:0]      elapsed;
    logic [3:0]       stall_inc;
    logic [3:0]       cold_inc;
    logic             flagged;
    logic             capped;

    assign elapsed   = item.now_ms - enter_time_reg;
    assign stall_inc = stall_cnt_reg + 4'd1;
    assign cold_inc  = cold_cnt_reg + 4'd1;
    assign capped    = (cfg.max_recovery != 8'd0) && (recov_reg >= cfg.max_recovery);

    always_comb
    begin
        enter_time_next   = enter_time_reg;
        handler_busy_next = handler_busy_reg;
        prev_dma_next     = prev_dma_reg;
        stall_cnt_next    = stall_cnt_reg;
        cold_cnt_next     = cold_cnt_reg;
        fault_next        = fault_reg;
        recov_next        = recov_reg;
        escalated_next    = escalated_reg;
        flagged           = 1'b0;

        result.status           = ssrm_pkg::ST_OK;
        result.action           = ssrm_pkg::ACT_NONE;
        result.fault_count_bump = 1'b0;
        result.clear_dma_count  = 1'b0;

        case (ssrm_pkg::cmd_t'(item.command))
            ssrm_pkg::CMD_HANDLER_ENTER:
            begin
                enter_time_next   = item.now_ms;
                handler_busy_next = 1'b1;
            end
            ssrm_pkg::CMD_HANDLER_EXIT:
            begin
                handler_busy_next = 1'b0;
            end
            ssrm_pkg::CMD_SESSION_RESET:
            begin
                recov_next     = 8'd0;
                stall_cnt_next = 4'd0;
                cold_cnt_next  = 4'd0;
                fault_next     = ssrm_pkg::FAULT_NONE;
                escalated_next = 1'b0;
                prev_dma_next  = 32'd0;
            end
            ssrm_pkg::CMD_TICK:
            begin
                if (handler_busy_reg && (elapsed >= {16'd0, cfg.handler_timeout_ms}))
                begin
                    result.status = ssrm_pkg::ST_HANDLER_WEDGED;
                    result.action = ssrm_pkg::ACT_HANDLER_RESET;
                end
                else if (item.app_active)
                begin
                    // sampler
                    if (item.dma_count != prev_dma_reg)
                    begin
                        stall_cnt_next = 4'd0;
                        cold_cnt_next  = 4'd0;
                        prev_dma_next  = item.dma_count;
                    end
                    else if ((item.dma_count != 32'd0) && item.sm_busy_wait)
                    begin
                        cold_cnt_next = 4'd0;
                        if (stall_inc >= cfg.stall_ticks)
                        begin
                            stall_cnt_next = 4'd0;
                            fault_next     = ssrm_pkg::FAULT_STALL;
                            flagged        = 1'b1;
                        end
                        else
                        begin
                            stall_cnt_next = stall_inc;
                        end
                    end
                    else if ((item.dma_count == 32'd0) && item.sm_streaming_active)
                    begin
                        stall_cnt_next = 4'd0;
                        if (cold_inc >= cfg.cold_start_ticks)
                        begin
                            cold_cnt_next = 4'd0;
                            fault_next    = ssrm_pkg::FAULT_COLD;
                            flagged       = 1'b1;
                        end
                        else
                        begin
                            cold_cnt_next = cold_inc;
                        end
                    end
                    else
                    begin
                        stall_cnt_next = 4'd0;
                        cold_cnt_next  = 4'd0;
                    end

                    // recovery choice
                    if (flagged)
                    begin
                        result.status = ssrm_pkg::ST_STREAM_WEDGED;
                        if (capped)
                        begin
                            if ((fault_next == ssrm_pkg::FAULT_COLD) && cfg.escalation_enable
                                && !escalated_reg && item.clock_healthy)
                            begin
                                escalated_next          = 1'b1;
                                result.fault_count_bump = 1'b1;
                                result.action           = ssrm_pkg::ACT_ESCALATED;
                            end
                            else
                            begin
                                result.action = ssrm_pkg::ACT_CAPPED_WAIT;
                            end
                        end
                        else
                        begin
                            if (recov_reg != ssrm_pkg::RECOVERY_MAX)
                            begin
                                recov_next = recov_reg + 8'd1;
                            end
                            result.action = item.clock_healthy ? ssrm_pkg::ACT_RECOVER_RST
                                                               : ssrm_pkg::ACT_RECOVER_NORST;
                            result.fault_count_bump = 1'b1;
                            result.clear_dma_count  = 1'b1;
                            prev_dma_next           = 32'd0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.fault_kind     = fault_next;
        result.recovery_count = recov_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_time_reg   <= 32'd0;
            handler_busy_reg <= 1'b0;
            prev_dma_reg     <= 32'd0;
            stall_cnt_reg    <= 4'd0;
            cold_cnt_reg     <= 4'd0;
            fault_reg        <= ssrm_pkg::FAULT_NONE;
            recov_reg        <= 8'd0;
            escalated_reg    <= 1'b0;
        end
        else if (fire)
        begin
            enter_time_reg   <= enter_time_next;
            handler_busy_reg <= handler_busy_next;
            prev_dma_reg     <= prev_dma_next;
            stall_cnt_reg    <= stall_cnt_next;
            cold_cnt_reg     <= cold_cnt_next;
            fault_reg        <= fault_next;
            recov_reg        <= recov_next;
            escalated_reg    <= escalated_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ssrm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssrm_checker
// Port-level checks for the stream stall recovery monitor.
// ----------------------------------------------------------------------------
module ssrm_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [1:0] status,
    input  wire logic [2:0] action,
    input  wire logic       fault_count_bump,
    input  wire logic       clear_dma_count,
    input  wire logic [7:0] recovery_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) && $stable(recovery_count))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    a_handler_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ssrm_pkg::ACT_HANDLER_RESET) |->
            (status == ssrm_pkg::ST_HANDLER_WEDGED) && !fault_count_bump && !clear_dma_count)
        else $error("handler reset with wrong status");

    a_recover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((action == ssrm_pkg::ACT_RECOVER_RST)
            || (action == ssrm_pkg::ACT_RECOVER_NORST)) |->
            (status == ssrm_pkg::ST_STREAM_WEDGED) && fault_count_bump && clear_dma_count
            && (recovery_count != 8'd0))
        else $error("recovery without its side effects");

    a_ok_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ssrm_pkg::ST_OK) |->
            (action == ssrm_pkg::ACT_NONE) && !fault_count_bump && !clear_dma_count)
        else $error("action reported with ok status");

endmodule

bind stream_stall_recovery_monitor_top ssrm_checker u_ssrm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .action           (action),
    .fault_count_bump (fault_count_bump),
    .clear_dma_count  (clear_dma_count),
    .recovery_count   (recovery_count)
);
`default_nettype wire

[tb/tb_stream_stall_recovery_monitor_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_stall_recovery_monitor_top
// Self-checking bench for the stream stall recovery monitor. A queue-fed
// driver pushes commands with random idle bursts, a monitor applies random
// output stall bursts and checks every result against a cycle-free model of
// the handler timeout, stall and cold-start sampler and recovery selection.
// Directed items come first, then randomized episodes over several register
// settings, including zero thresholds, zero timeout and recovery saturation.
// ----------------------------------------------------------------------------
module tb_stream_stall_recovery_monitor_top;

    localparam int CYCLE_LIMIT = 500000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ssrm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ssrm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [1:0]                      command = '0;
    logic [31:0]                     now_ms = '0;
    logic [31:0]                     dma_count = '0;
    logic                            sm_busy_wait = 1'b0;
    logic                            sm_streaming_active = 1'b0;
    logic                            app_active = 1'b0;
    logic                            clock_healthy = 1'b0;

    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      status;
    logic [2:0]                      action;
    logic [1:0]                      fault_kind;
    logic                            fault_count_bump;
    logic                            clear_dma_count;
    logic [7:0]                      recovery_count;

    stream_stall_recovery_monitor_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .command             (command),
        .now_ms              (now_ms),
        .dma_count           (dma_count),
        .sm_busy_wait        (sm_busy_wait),
        .sm_streaming_active (sm_streaming_active),
        .app_active          (app_active),
        .clock_healthy       (clock_healthy),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .action              (action),
        .fault_kind          (fault_kind),
        .fault_count_bump    (fault_count_bump),
        .clear_dma_count     (clear_dma_count),
        .recovery_count      (recovery_count)
    );

    always #5 clk = ~clk;

    // model state
    ssrm_pkg::cfg_t     cfg_now;
    logic [31:0]        m_handler_t0;
    logic               m_handler_busy;
    logic [31:0]        m_last_dma;
    logic [3:0]         m_stall_run;
    logic [3:0]         m_cold_run;
    ssrm_pkg::fault_t   m_fault;
    logic [7:0]         m_recoveries;
    logic               m_escalated;

    ssrm_pkg::item_t    pending_cmds[$];
    ssrm_pkg::result_t  expected_verdicts[$];
    ssrm_pkg::item_t    in_flight;
    int                 cmds_queued = 0;
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 in_idle_pct = 0;
    int                 out_idle_pct = 0;
    int                 in_gap = 0;
    int                 out_gap = 0;
    logic [31:0]        gen_now = '0;
    logic [31:0]        gen_dma = '0;

    function automatic void clear_session();
        m_recoveries = '0;
        m_stall_run  = '0;
        m_cold_run   = '0;
        m_fault      = ssrm_pkg::FAULT_NONE;
        m_escalated  = 1'b0;
        m_last_dma   = '0;
    endfunction

    function automatic ssrm_pkg::result_t health_step(ssrm_pkg::item_t it);
        ssrm_pkg::result_t r;
        logic [31:0]       elapsed;
        logic              flagged;
        r = '0;
        r.status = ssrm_pkg::ST_OK;
        r.action = ssrm_pkg::ACT_NONE;
        flagged = 1'b0;
        elapsed = it.now_ms - m_handler_t0;
        case (ssrm_pkg::cmd_t'(it.command))
            ssrm_pkg::CMD_HANDLER_ENTER:
            begin
                m_handler_t0   = it.now_ms;
                m_handler_busy = 1'b1;
            end
            ssrm_pkg::CMD_HANDLER_EXIT:
            begin
                m_handler_busy = 1'b0;
            end
            ssrm_pkg::CMD_SESSION_RESET:
            begin
                clear_session();
            end
            default:
            begin
                if (m_handler_busy && elapsed >= {16'd0, cfg_now.handler_timeout_ms})
                begin
                    r.status = ssrm_pkg::ST_HANDLER_WEDGED;
                    r.action = ssrm_pkg::ACT_HANDLER_RESET;
                end
                else if (it.app_active)
                begin
                    // sampler
                    if (it.dma_count != m_last_dma)
                    begin
                        m_stall_run = '0;
                        m_cold_run  = '0;
                        m_last_dma  = it.dma_count;
                    end
                    else if (it.dma_count != 32'd0 && it.sm_busy_wait)
                    begin
                        m_cold_run  = '0;
                        m_stall_run = m_stall_run + 4'd1;
                        if (m_stall_run >= cfg_now.stall_ticks)
                        begin
                            m_stall_run = '0;
                            m_fault     = ssrm_pkg::FAULT_STALL;
                            flagged     = 1'b1;
                        end
                    end
                    else if (it.dma_count == 32'd0 && it.sm_streaming_active)
                    begin
                        m_stall_run = '0;
                        m_cold_run  = m_cold_run + 4'd1;
                        if (m_cold_run >= cfg_now.cold_start_ticks)
                        begin
                            m_cold_run = '0;
                            m_fault    = ssrm_pkg::FAULT_COLD;
                            flagged    = 1'b1;
                        end
                    end
                    else
                    begin
                        m_stall_run = '0;
                        m_cold_run  = '0;
                    end

                    if (flagged)
                    begin
                        r.status = ssrm_pkg::ST_STREAM_WEDGED;
                        if (cfg_now.max_recovery != 8'd0
                            && m_recoveries >= cfg_now.max_recovery)
                        begin
                            if (m_fault == ssrm_pkg::FAULT_COLD && cfg_now.escalation_enable
                                && !m_escalated && it.clock_healthy)
                            begin
                                m_escalated        = 1'b1;
                                r.fault_count_bump = 1'b1;
                                r.action           = ssrm_pkg::ACT_ESCALATED;
                            end
                            else
                            begin
                                r.action = ssrm_pkg::ACT_CAPPED_WAIT;
                            end
                        end
                        else
                        begin
                            if (m_recoveries < ssrm_pkg::RECOVERY_MAX)
                                m_recoveries = m_recoveries + 8'd1;
                            r.action = it.clock_healthy ? ssrm_pkg::ACT_RECOVER_RST
                                                        : ssrm_pkg::ACT_RECOVER_NORST;
                            r.fault_count_bump = 1'b1;
                            r.clear_dma_count  = 1'b1;
                            m_last_dma         = '0;
                        end
                    end
                end
            end
        endcase
        r.fault_kind     = m_fault;
        r.recovery_count = m_recoveries;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_verdicts.push_back(health_step(in_flight));
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap--;
                end
                else if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct)
                begin
                    in_valid <= 1'b0;
                    in_gap = $urandom_range(0, 14);
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_flight = pending_cmds.pop_front();
                    in_valid            <= 1'b1;
                    command             <= in_flight.command;
                    now_ms              <= in_flight.now_ms;
                    dma_count           <= in_flight.dma_count;
                    sm_busy_wait        <= in_flight.sm_busy_wait;
                    sm_streaming_active <= in_flight.sm_streaming_active;
                    app_active          <= in_flight.app_active;
                    clock_healthy       <= in_flight.clock_healthy;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        ssrm_pkg::result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    report_mismatch("unexpected result, action", 32'(action),
                                    32'(ssrm_pkg::ACT_NONE));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (action !== want.action)
                        report_mismatch("action", 32'(action), 32'(want.action));
                    if (fault_kind !== want.fault_kind)
                        report_mismatch("fault_kind", 32'(fault_kind), 32'(want.fault_kind));
                    if (fault_count_bump !== want.fault_count_bump)
                        report_mismatch("fault_count_bump", 32'(fault_count_bump),
                                        32'(want.fault_count_bump));
                    if (clear_dma_count !== want.clear_dma_count)
                        report_mismatch("clear_dma_count", 32'(clear_dma_count),
                                        32'(want.clear_dma_count));
                    if (recovery_count !== want.recovery_count)
                        report_mismatch("recovery_count", 32'(recovery_count),
                                        32'(want.recovery_count));
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap--;
            end
            else if (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct)
            begin
                out_stall <= 1'b1;
                out_gap = $urandom_range(0, 14);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_stream_stall_recovery_monitor_top: errors");
            $finish;
        end
    end

    task automatic add_item(input ssrm_pkg::cmd_t c, input logic [31:0] t,
                            input logic [31:0] d, input logic bw, input logic sa,
                            input logic ap, input logic ck);
        ssrm_pkg::item_t it;
        it.command             = c;
        it.now_ms              = t;
        it.dma_count           = d;
        it.sm_busy_wait        = bw;
        it.sm_streaming_active = sa;
        it.app_active          = ap;
        it.clock_healthy       = ck;
        pending_cmds.push_back(it);
        cmds_queued++;
    endtask

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [31:0] next_time();
        int roll;
        roll = $urandom_range(99);
        if (roll < 90)
            gen_now = gen_now + $urandom_range(0, 400);
        else if (roll < 97)
            gen_now = gen_now + $urandom_range(0, 70000);
        else
            gen_now = $urandom;
        return gen_now;
    endfunction

    task automatic push_episode();
        int          kind;
        int          len;
        logic [31:0] d;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 20);
        case (kind)
            0, 1, 2:
            begin
                // frozen progress
                d = (gen_dma != 0 && rand_bit()) ? gen_dma : $urandom;
                if (d == 0)
                    d = 32'd1;
                repeat (len)
                    add_item(ssrm_pkg::CMD_TICK, next_time(), d, $urandom_range(9) != 0,
                             rand_bit(), $urandom_range(19) != 0,
                             $urandom_range(3) != 0);
                gen_dma = d;
            end
            3, 4:
            begin
                // cold start
                repeat (len)
                    add_item(ssrm_pkg::CMD_TICK, next_time(), 32'd0, rand_bit(),
                             $urandom_range(9) != 0, $urandom_range(19) != 0,
                             $urandom_range(3) != 0);
                gen_dma = '0;
            end
            5:
            begin
                repeat (len % 8 + 1)
                begin
                    gen_dma = gen_dma + $urandom_range(1, 4);
                    add_item(ssrm_pkg::CMD_TICK, next_time(), gen_dma, rand_bit(),
                             rand_bit(), 1'b1, rand_bit());
                end
            end
            6:
            begin
                // control handler running across ticks
                add_item(ssrm_pkg::CMD_HANDLER_ENTER, next_time(), $urandom, rand_bit(),
                         rand_bit(), rand_bit(), rand_bit());
                repeat (len)
                    add_item(ssrm_pkg::CMD_TICK, next_time(), gen_dma, rand_bit(),
                             rand_bit(), $urandom_range(9) != 0, rand_bit());
                if (rand_bit())
                    add_item(ssrm_pkg::CMD_HANDLER_EXIT, next_time(), $urandom, rand_bit(),
                             rand_bit(), rand_bit(), rand_bit());
            end
            7:
            begin
                add_item(ssrm_pkg::CMD_SESSION_RESET, next_time(), $urandom, rand_bit(),
                         rand_bit(), rand_bit(), rand_bit());
            end
            8:
            begin
                // noise
                repeat ($urandom_range(1, 4))
                begin
                    gen_now = $urandom;
                    add_item(ssrm_pkg::cmd_t'($urandom_range(3)), gen_now, $urandom,
                             rand_bit(), rand_bit(), rand_bit(), rand_bit());
                end
            end
            default:
            begin
                repeat (len)
                    add_item(ssrm_pkg::CMD_TICK, next_time(), gen_dma, rand_bit(),
                             rand_bit(), 1'b0, rand_bit());
            end
        endcase
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_verdicts.size() != 0);
    endtask

    task automatic program_cfg(input ssrm_pkg::cfg_t c);
        logic [ssrm_pkg::CFG_DATA_W-1:0] word;
        logic [ssrm_pkg::CFG_IDX_W-1:0]  idx;
        @(posedge clk);
        for (int i = 0; i <= ssrm_pkg::CFG_COLD_START_TICKS; i++)
        begin
            idx = i[ssrm_pkg::CFG_IDX_W-1:0];
            case (idx)
                ssrm_pkg::CFG_MAX_RECOVERY:       word = {8'd0, c.max_recovery};
                ssrm_pkg::CFG_ESCALATION_ENABLE:  word = {15'd0, c.escalation_enable};
                ssrm_pkg::CFG_HANDLER_TIMEOUT_MS: word = c.handler_timeout_ms;
                ssrm_pkg::CFG_STALL_TICKS:        word = {12'd0, c.stall_ticks};
                default:                          word = {12'd0, c.cold_start_ticks};
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_now = c;
    endtask

    task automatic run_phase(input ssrm_pkg::cfg_t c, input int in_pct, input int out_pct,
                             input int cold_run, input int n);
        int stop;
        program_cfg(c);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        // no handler left running so the cold run reaches the sampler
        if (cold_run > 0)
            add_item(ssrm_pkg::CMD_HANDLER_EXIT, next_time(), 32'd0, 1'b0, 1'b0, 1'b0,
                     1'b0);
        repeat (cold_run)
            add_item(ssrm_pkg::CMD_TICK, next_time(), 32'd0, rand_bit(), 1'b1, 1'b1,
                     rand_bit());
        stop = cmds_queued + n;
        while (cmds_queued < stop)
            push_episode();
        drain();
    endtask

    initial
    begin
        cfg_now = ssrm_pkg::cfg_t'{ssrm_pkg::RST_MAX_RECOVERY,
                                   ssrm_pkg::RST_ESCALATION_ENABLE,
                                   ssrm_pkg::RST_HANDLER_TIMEOUT_MS,
                                   ssrm_pkg::RST_STALL_TICKS,
                                   ssrm_pkg::RST_COLD_START_TICKS};
        m_handler_t0   = '0;
        m_handler_busy = 1'b0;
        clear_session();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed items on reset register values
        in_idle_pct  = 5;
        out_idle_pct = 5;
        add_item(ssrm_pkg::CMD_TICK, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1);
        add_item(ssrm_pkg::CMD_HANDLER_ENTER, 32'd100, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(ssrm_pkg::CMD_TICK, 32'd2099, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        add_item(ssrm_pkg::CMD_TICK, 32'd2100, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        add_item(ssrm_pkg::CMD_TICK, 32'd5000, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1);
        add_item(ssrm_pkg::CMD_HANDLER_EXIT, 32'd5001, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(ssrm_pkg::CMD_HANDLER_ENTER, 32'hFFFF_FF00, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(ssrm_pkg::CMD_TICK, 32'h0000_0700, 32'd0, 1'b0, 1'b0, 1'b1, 1'b1);
        add_item(ssrm_pkg::CMD_HANDLER_EXIT, 32'h0000_0701, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        repeat (5)
            add_item(ssrm_pkg::CMD_TICK, 32'd3000, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1);
        add_item(ssrm_pkg::CMD_TICK, 32'd3100, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0);
        repeat (3)
            add_item(ssrm_pkg::CMD_TICK, 32'd3200, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0);
        add_item(ssrm_pkg::CMD_SESSION_RESET, 32'd3300, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
                 1'b1);
        add_item(ssrm_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        add_item(ssrm_pkg::CMD_HANDLER_ENTER, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        add_item(ssrm_pkg::CMD_HANDLER_EXIT, 32'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        add_item(ssrm_pkg::CMD_TICK, 32'd2, 32'd0, 1'b1, 1'b0, 1'b1, 1'b0);
        gen_now = 32'd10;
        drain();

        run_phase(ssrm_pkg::cfg_t'{8'd3, 1'b1, 16'd2000, 4'd3, 4'd5}, 10, 10, 0, 90);
        run_phase(ssrm_pkg::cfg_t'{8'd1, 1'b1, 16'd0, 4'd0, 4'd0}, 5, 15, 0, 70);
        run_phase(ssrm_pkg::cfg_t'{8'd0, 1'b0, 16'hFFFF, 4'd15, 4'd15}, 15, 5, 0, 70);
        // unlimited recoveries until the count saturates
        run_phase(ssrm_pkg::cfg_t'{8'd0, 1'b1, 16'd1, 4'd1, 4'd1}, 0, 0, 270, 0);
        // count already at the cap
        run_phase(ssrm_pkg::cfg_t'{8'd255, 1'b1, 16'd500, 4'd2, 4'd2}, 8, 8, 20, 50);
        run_phase(ssrm_pkg::cfg_t'{8'd2, 1'b0, 16'd300, 4'd4, 4'd3}, 0, 0, 0, 70);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_stream_stall_recovery_monitor_top: clean");
        else
            $display("tb_stream_stall_recovery_monitor_top: errors");
        $finish;
    end

endmodule
